>>> rtl/core/drph_pkg.sv
// Package for the digital-root probing hash table.
// Holds widths, codes, the interface structs and the hash helper functions.
// Used by every module under rtl/core.
package drph_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int KEY_WIDTH   = 27;
    localparam int FIELD_W     = 32;
    localparam int STATUS_W    = 2;
    localparam int SLOT_COUNT  = 10;
    localparam int PROBE_LIMIT = 10;
    localparam int MOD_BASE    = 9;
    localparam int SLOT_W      = $clog2(SLOT_COUNT);
    localparam int CNT_W       = $clog2(PROBE_LIMIT);
    localparam int DIGIT_W     = 6;
    localparam int SUM_W       = 9;
    localparam int RED_W       = 7;
    localparam int S_DATA_W    = 64;
    localparam int M_DATA_W    = 40;

    localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(SLOT_COUNT - 1);
    localparam logic [SLOT_W-1:0] RING_START = SLOT_W'(1);
    localparam logic [SLOT_W-1:0] NO_SLOT    = '0;
    localparam logic [CNT_W-1:0]  LAST_PROBE = CNT_W'(PROBE_LIMIT - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_PROBE
    } t_state;

    typedef enum logic [STATUS_W-1:0] {
        STAT_STORED    = 2'd0,
        STAT_FOUND     = 2'd1,
        STAT_NOT_FOUND = 2'd2,
        STAT_FULL      = 2'd3
    } t_status;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_SEARCH = 1'b1
    } t_op;

    typedef struct packed {
        logic                   en;
        logic [SLOT_W-1:0]      slot;
        logic [KEY_WIDTH-1:0]   key;
        logic [VALUE_WIDTH-1:0] value;
    } t_store_wr;

    typedef struct packed {
        logic                   occupied;
        logic                   match;
        logic [VALUE_WIDTH-1:0] value;
    } t_probe;

    // Base-64 digit sum: 64 is 1 modulo 9, so the sum keeps the residue.
    function automatic logic [SUM_W-1:0] f_digit_sum(input logic [KEY_WIDTH-1:0] key);
        return SUM_W'(key[DIGIT_W-1:0])
             + SUM_W'(key[2*DIGIT_W-1:DIGIT_W])
             + SUM_W'(key[3*DIGIT_W-1:2*DIGIT_W])
             + SUM_W'(key[4*DIGIT_W-1:3*DIGIT_W])
             + SUM_W'(key[KEY_WIDTH-1:4*DIGIT_W]);
    endfunction

    function automatic logic [SLOT_W-1:0] f_home_slot(input logic [SUM_W-1:0] sum,
                                                      input logic            key_zero);
        logic [RED_W-1:0] m;
        m = RED_W'(sum[DIGIT_W-1:0]) + RED_W'(sum[SUM_W-1:DIGIT_W]);
        if (m >= RED_W'(4 * MOD_BASE)) m = m - RED_W'(4 * MOD_BASE);
        if (m >= RED_W'(2 * MOD_BASE)) m = m - RED_W'(2 * MOD_BASE);
        if (m >= RED_W'(MOD_BASE))     m = m - RED_W'(MOD_BASE);
        if (key_zero) begin
            return NO_SLOT;
        end else if (m == '0) begin
            return LAST_SLOT;
        end
        return SLOT_W'(m);
    endfunction

    function automatic logic [SLOT_W-1:0] f_next_slot(input logic [SLOT_W-1:0] slot);
        return (slot == LAST_SLOT) ? RING_START : slot + SLOT_W'(1);
    endfunction

endpackage

>>> rtl/core/drph_store.sv
// Slot store of the hash table: key/value memory with a registered read port
// and per-slot occupancy flags. Depends on drph_pkg.
module drph_store (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [drph_pkg::SLOT_W-1:0]    i_rd_slot,
    input  logic [drph_pkg::SLOT_W-1:0]    i_cur_slot,
    input  logic [drph_pkg::KEY_WIDTH-1:0] i_key,
    input  drph_pkg::t_store_wr       i_wr,
    output drph_pkg::t_probe          o_probe
);
    import drph_pkg::*;

    logic [KEY_WIDTH+VALUE_WIDTH-1:0] mem [SLOT_COUNT];
    logic [KEY_WIDTH+VALUE_WIDTH-1:0] r_rd;
    logic [SLOT_COUNT-1:0]            r_valid;
    logic [KEY_WIDTH-1:0]             w_rd_key;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.slot] <= {i_wr.key, i_wr.value};
        end
        r_rd <= mem[i_rd_slot];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.en) begin
            r_valid[i_wr.slot] <= 1'b1;
        end
    end

    assign w_rd_key          = r_rd[KEY_WIDTH+VALUE_WIDTH-1:VALUE_WIDTH];
    assign o_probe.occupied  = r_valid[i_cur_slot];
    assign o_probe.match     = r_valid[i_cur_slot] && (w_rd_key == i_key);
    assign o_probe.value     = r_rd[VALUE_WIDTH-1:0];

endmodule

>>> rtl/core/digital_root_probe_hash_table_top.sv
// Top level of the digital-root probing hash table.
// Request sequencer, result register and the slot store; depends on drph_pkg.
//
// Usage:
//   Requests arrive on the slave stream: s_tuser carries the opcode (insert or
//   search), s_tdata the key and the value. One request is worked at a time;
//   o_s_tready is high only while the sequencer is idle.
//   Each request produces exactly one result on the master stream: m_tuser is
//   the status (stored, found, not found, table full), m_tdata the found value
//   and the slot used.
//   Steps: the transfer, a hash-reduce state, then one probe per slot visited,
//   each probe being one read of the slot memory. A request makes 1 to 10
//   probes; the probe count is set by how many occupied slots lie on the
//   key's chain. The next request is taken once the sequencer is back in idle.
//   The result register frees the input side: a new request is taken while a
//   result still waits. If the receiver stalls and the next result is ready,
//   the sequencer holds on its final probe until the register drains.
//   Reset (synchronous, active low) empties every slot and drops any result.
module digital_root_probe_hash_table_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // [26:0] lookup_key, [58:27] entry_value, [63:59] zero
    input  logic [drph_pkg::S_DATA_W-1:0] i_s_tdata,
    // [0] opcode
    input  logic                          i_s_tuser,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // [31:0] found_value, [35:32] slot_used, [39:36] zero
    output logic [drph_pkg::M_DATA_W-1:0] o_m_tdata,
    // [1:0] status
    output logic [drph_pkg::STATUS_W-1:0] o_m_tuser
);
    import drph_pkg::*;

    t_state                 r_state, n_state;
    t_op                    r_op, n_op;
    logic [KEY_WIDTH-1:0]   r_key, n_key;
    logic [VALUE_WIDTH-1:0] r_val, n_val;
    logic [SUM_W-1:0]       r_sum, n_sum;
    logic                   r_zero, n_zero;
    logic [SLOT_W-1:0]      r_slot, n_slot;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic                   r_out_valid, n_out_valid;
    t_status                r_out_status, n_out_status;
    logic [FIELD_W-1:0]     r_out_found, n_out_found;
    logic [SLOT_W-1:0]      r_out_slot, n_out_slot;

    t_store_wr              w_wr;
    t_probe                 w_probe;
    logic [63:0]            w_found_wide;
    logic                   w_accept;
    logic                   w_out_free;
    logic                   w_done;
    t_status                w_status;
    logic [FIELD_W-1:0]     w_found;
    logic [SLOT_W-1:0]      w_used;

    drph_store u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_slot  (n_slot),
        .i_cur_slot (r_slot),
        .i_key      (r_key),
        .i_wr       (w_wr),
        .o_probe    (w_probe)
    );

    assign o_s_tready   = (r_state == ST_IDLE);
    assign w_accept     = i_s_tvalid && o_s_tready;
    assign w_out_free   = !r_out_valid || i_m_tready;
    assign w_found_wide = 64'(w_probe.value);

    always_comb begin
        w_done   = 1'b0;
        w_status = STAT_FULL;
        w_found  = '0;
        w_used   = NO_SLOT;
        if (r_op == OP_INSERT) begin
            if (!w_probe.occupied || w_probe.match) begin
                w_done   = 1'b1;
                w_status = STAT_STORED;
                w_used   = r_slot;
            end
        end else begin
            if (w_probe.match) begin
                w_done   = 1'b1;
                w_status = STAT_FOUND;
                w_found  = w_found_wide[FIELD_W-1:0];
                w_used   = r_slot;
            end else if (!w_probe.occupied) begin
                w_done   = 1'b1;
                w_status = STAT_NOT_FOUND;
            end
        end
        if (r_cnt == LAST_PROBE) begin
            w_done = 1'b1;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_key        = r_key;
        n_val        = r_val;
        n_sum        = r_sum;
        n_zero       = r_zero;
        n_slot       = r_slot;
        n_cnt        = r_cnt;
        n_out_valid  = r_out_valid && !i_m_tready;
        n_out_status = r_out_status;
        n_out_found  = r_out_found;
        n_out_slot   = r_out_slot;
        w_wr.en      = 1'b0;
        w_wr.slot    = r_slot;
        w_wr.key     = r_key;
        w_wr.value   = r_val;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_op    = t_op'(i_s_tuser);
                    n_key   = i_s_tdata[KEY_WIDTH-1:0];
                    n_val   = VALUE_WIDTH'(i_s_tdata[KEY_WIDTH+FIELD_W-1:KEY_WIDTH]);
                    n_sum   = f_digit_sum(i_s_tdata[KEY_WIDTH-1:0]);
                    n_zero  = (i_s_tdata[KEY_WIDTH-1:0] == '0);
                    n_state = ST_REDUCE;
                end
            end
            ST_REDUCE: begin
                n_slot  = f_home_slot(r_sum, r_zero);
                n_cnt   = '0;
                n_state = ST_PROBE;
            end
            ST_PROBE: begin
                if (w_done) begin
                    if (w_out_free) begin
                        w_wr.en      = (w_status == STAT_STORED);
                        n_out_valid  = 1'b1;
                        n_out_status = w_status;
                        n_out_found  = w_found;
                        n_out_slot   = w_used;
                        n_state      = ST_IDLE;
                    end
                end else begin
                    n_cnt  = r_cnt + CNT_W'(1);
                    n_slot = f_next_slot(r_slot);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_slot      <= NO_SLOT;
            r_cnt       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_slot      <= n_slot;
            r_cnt       <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_key        <= n_key;
        r_val        <= n_val;
        r_sum        <= n_sum;
        r_zero       <= n_zero;
        r_out_status <= n_out_status;
        r_out_found  <= n_out_found;
        r_out_slot   <= n_out_slot;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_status;
    assign o_m_tdata  = {(M_DATA_W - FIELD_W - SLOT_W)'(0), r_out_slot, r_out_found};

endmodule

>>> rtl/core/drph_checker.sv
// Port-level checker for the digital-root probing hash table, bound to the
// top level. Depends on drph_pkg.
module drph_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_s_tvalid,
    input logic                          o_s_tready,
    input logic [drph_pkg::S_DATA_W-1:0] i_s_tdata,
    input logic                          i_s_tuser,
    input logic                          o_m_tvalid,
    input logic                          i_m_tready,
    input logic [drph_pkg::M_DATA_W-1:0] o_m_tdata,
    input logic [drph_pkg::STATUS_W-1:0] o_m_tuser
);
    import drph_pkg::*;

    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("request taken while another is in flight");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
            (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser)))
        else $error("stalled result changed");

    a_value_only_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser != STAT_FOUND)) |-> (o_m_tdata[FIELD_W-1:0] == '0))
        else $error("value reported without a match");

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[FIELD_W+SLOT_W-1:FIELD_W] <= LAST_SLOT))
        else $error("slot out of range");

    a_no_slot_on_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && ((o_m_tuser == STAT_NOT_FOUND) || (o_m_tuser == STAT_FULL)))
            |-> (o_m_tdata[FIELD_W+SLOT_W-1:FIELD_W] == NO_SLOT))
        else $error("slot reported on a miss");

endmodule

bind digital_root_probe_hash_table_top drph_checker u_drph_checker (.*);

>>> bench/drph_reply_checker.sv
`timescale 1ns / 1ps
// Result checker for the digital-root probing hash table.
// Keeps its own ten-slot table from observed request transfers and checks result transfers
// in order. Depends on drph_pkg.
module drph_reply_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    input  logic                          i_s_tready,
    // [26:0] lookup_key, [58:27] entry_value, [63:59] zero
    input  logic [drph_pkg::S_DATA_W-1:0] i_s_tdata,
    // [0] opcode
    input  logic                          i_s_tuser,
    input  logic                          i_m_tvalid,
    input  logic                          i_m_tready,
    // [31:0] found_value, [35:32] slot_used, [39:36] zero
    input  logic [drph_pkg::M_DATA_W-1:0] i_m_tdata,
    // [1:0] status
    input  logic [drph_pkg::STATUS_W-1:0] i_m_tuser,
    output int                            o_fail_count,
    output int                            o_waiting,
    output logic [3:0][15:0]              o_status_hits
);
    import drph_pkg::*;

    typedef struct packed {
        t_status                status;
        logic [FIELD_W-1:0]     word;
        logic [SLOT_W-1:0]      slot;
    } t_reply;

    logic                   live      [SLOT_COUNT];
    logic [KEY_WIDTH-1:0]   kept_key  [SLOT_COUNT];
    logic [VALUE_WIDTH-1:0] kept_word [SLOT_COUNT];
    t_reply                 replies_due [$];
    t_reply                 want;
    int                     errs = 0;

    function automatic logic [SLOT_W-1:0] root_of(input logic [KEY_WIDTH-1:0] n);
        if (n == '0) return '0;
        return SLOT_W'(1 + (n - 1) % MOD_BASE);
    endfunction

    // Walk the probe chain and update the table copy, as one request does.
    function automatic t_reply run_request(input t_op op, input logic [KEY_WIDTH-1:0] key,
                                           input logic [VALUE_WIDTH-1:0] word);
        t_reply             r;
        logic [SLOT_W-1:0]  slot;
        logic               hit;
        r = '{STAT_FULL, '0, '0};
        slot = root_of(key);
        for (int p = 0; p < PROBE_LIMIT; p++) begin
            hit = live[slot] && kept_key[slot] == key;
            if (op == OP_INSERT) begin
                if (!live[slot] || hit) begin
                    live[slot] = 1'b1;
                    kept_key[slot] = key;
                    kept_word[slot] = word;
                    r = '{STAT_STORED, '0, slot};
                    return r;
                end
            end else if (hit) begin
                r = '{STAT_FOUND, FIELD_W'(kept_word[slot]), slot};
                return r;
            end else if (!live[slot]) begin
                r.status = STAT_NOT_FOUND;
                return r;
            end
            slot = root_of(KEY_WIDTH'(slot) + KEY_WIDTH'(1));
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (live[i]) live[i] = 1'b0;
            replies_due.delete();
            o_waiting <= 0;
            o_fail_count <= errs;
            o_status_hits <= '0;
        end else begin
            if (i_s_tvalid && i_s_tready)
                replies_due.push_back(run_request(t_op'(i_s_tuser), i_s_tdata[KEY_WIDTH-1:0],
                                                  i_s_tdata[KEY_WIDTH +: VALUE_WIDTH]));
            if (i_m_tvalid && i_m_tready) begin
                o_status_hits[i_m_tuser] <= o_status_hits[i_m_tuser] + 16'd1;
                if (replies_due.size() == 0) begin
                    $error("result transfer with no request outstanding: status %0d", i_m_tuser);
                    errs++;
                end else begin
                    want = replies_due.pop_front();
                    if (i_m_tuser !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, i_m_tuser);
                        errs++;
                    end
                    if (i_m_tdata[FIELD_W-1:0] !== want.word) begin
                        $error("found_value: expected %h, got %h", want.word,
                               i_m_tdata[FIELD_W-1:0]);
                        errs++;
                    end
                    if (i_m_tdata[FIELD_W +: SLOT_W] !== want.slot) begin
                        $error("slot_used: expected %0d, got %0d", want.slot,
                               i_m_tdata[FIELD_W +: SLOT_W]);
                        errs++;
                    end
                end
            end
            o_waiting <= replies_due.size();
            o_fail_count <= errs;
        end
    end

endmodule

>>> bench/tb_digital_root_probe_hash_table_top.sv
`timescale 1ns / 1ps
// Testbench top for the digital-root probing hash table: clock, reset, request stimulus,
// result back-pressure and the verdict. Depends on drph_pkg and drph_reply_checker.
module tb_digital_root_probe_hash_table_top;

    import drph_pkg::*;

    localparam int LONG_HOLD = 200;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic                s_tuser = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0] m_tuser;

    int                  fail_count;
    int                  waiting;
    logic [3:0][15:0]    status_hits;

    int                  send_idle = 23;
    int                  recv_idle = 78;
    logic                hold_armed = 1'b0;
    logic                hold_spent = 1'b0;
    int                  hold_left = 0;
    int                  inserts = 0;
    int                  searches = 0;
    logic [KEY_WIDTH-1:0] used_keys [$];

    always #5 clk = ~clk;

    digital_root_probe_hash_table_top dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    drph_reply_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_s_tuser     (s_tuser),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .i_m_tuser     (m_tuser),
        .o_fail_count  (fail_count),
        .o_waiting     (waiting),
        .o_status_hits (status_hits)
    );

    // Hold off the result side once for a long stretch when armed.
    always @(posedge clk) begin
        if (hold_armed && !hold_spent) begin
            hold_spent <= 1'b1;
            hold_left <= LONG_HOLD;
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    task automatic issue_request(input t_op op, input logic [KEY_WIDTH-1:0] key,
                                 input logic [VALUE_WIDTH-1:0] word);
        while ($urandom_range(0, 99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= S_DATA_W'({word, key});
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        if (op == OP_INSERT) begin
            inserts++;
            used_keys.push_back(key);
        end else begin
            searches++;
        end
    endtask

    function automatic logic [KEY_WIDTH-1:0] pick_key();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 40 && used_keys.size() != 0)
            return used_keys[$urandom_range(0, used_keys.size() - 1)];
        if (roll < 60)
            return KEY_WIDTH'($urandom_range(1900, 2099) * 10000 + $urandom_range(1, 12) * 100
                              + $urandom_range(1, 31));
        if (roll < 80)
            return KEY_WIDTH'($urandom_range(0, (1 << KEY_WIDTH) - 1));
        if (roll < 92)
            return KEY_WIDTH'($urandom_range(0, 40));
        case ($urandom_range(0, 2))
            0:       return '0;
            1:       return KEY_WIDTH'(99999999);
            default: return '1;
        endcase
    endfunction

    task automatic random_requests(input int count);
        for (int n = 0; n < count; n++)
            issue_request(t_op'($urandom_range(0, 1)), pick_key(), $urandom());
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        issue_request(OP_SEARCH, '0, 32'h1234_5678);
        issue_request(OP_SEARCH, KEY_WIDTH'(99999999), '0);
        issue_request(OP_INSERT, '0, '0);
        issue_request(OP_SEARCH, '0, '1);
        issue_request(OP_INSERT, '0, '1);
        issue_request(OP_SEARCH, '0, '0);
        issue_request(OP_INSERT, KEY_WIDTH'(20240229), 32'hA5A5_A5A5);
        issue_request(OP_INSERT, KEY_WIDTH'(12), 32'h0000_0001);
        issue_request(OP_SEARCH, KEY_WIDTH'(12), 32'hFFFF_0000);
        issue_request(OP_SEARCH, KEY_WIDTH'(21), '0);
        issue_request(OP_INSERT, '1, 32'h5A5A_5A5A);
        issue_request(OP_INSERT, KEY_WIDTH'(9), 32'h8000_0000);
        issue_request(OP_INSERT, KEY_WIDTH'(18), 32'h7FFF_FFFF);
        issue_request(OP_INSERT, KEY_WIDTH'(99999999), 32'hDEAD_BEEF);
        issue_request(OP_SEARCH, KEY_WIDTH'(99999999), '0);
        issue_request(OP_SEARCH, KEY_WIDTH'(27), '1);
        issue_request(OP_SEARCH, '1, '0);

        random_requests(145);

        send_idle <= 78;
        recv_idle <= 23;
        random_requests(145);

        // Fill the block against a stalled receiver, then run flat out.
        send_idle <= 0;
        recv_idle <= 0;
        hold_armed <= 1'b1;
        random_requests(145);

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (waiting != 0) @(posedge clk);
        repeat (20) @(posedge clk);

        $display("covered %0d requests: %0d inserts, %0d searches, with a %0d-cycle result stall",
                 inserts + searches, inserts, searches, LONG_HOLD);
        $display("results by status: stored %0d, found %0d, not found %0d, table full %0d",
                 status_hits[STAT_STORED], status_hits[STAT_FOUND],
                 status_hits[STAT_NOT_FOUND], status_hits[STAT_FULL]);
        if (fail_count == 0) begin
            $display("digital_root_probe_hash_table_top regression: pass");
        end else begin
            $display("digital_root_probe_hash_table_top regression: fail");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("timeout waiting for results");
        $display("digital_root_probe_hash_table_top regression: fail");
        $finish;
    end

endmodule
